/* rtl/pld_pkg.sv */
// Shared types and constants for the point-to-line distance pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package pld_pkg;

  localparam int QW = 50;  // quotient and value width
  localparam int RW = QW / 2;  // root width

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DEGEN  = 2'd1;
  localparam logic [1:0] STAT_OFFSEG = 2'd2;

  localparam int CMD_ROOT_BIT = 0;
  localparam int CMD_SEG_BIT  = 1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
  } in_t;

  typedef struct packed {
    logic [QW-1:0] value;
    logic [1:0]    status;
  } out_t;

  // sideband that travels with an item through the divider and root stages
  typedef struct packed {
    logic [1:0] status;
    logic       root;
  } side_t;

endpackage
`default_nettype wire

/* rtl/pld_front.sv */
// Front stages: differences, products, sums, squares, numerator build.
// Depends on pld_pkg.
`default_nettype none
module pld_front #(
  parameter int CW   = 16,
  parameter int FB   = 16,
  parameter int DIVW = 36,
  parameter int EW   = 88
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               adv,
  input  wire               in_vld,
  input  pld_pkg::in_t      in_item,
  output logic              o_vld,
  output logic [EW-1:0]     o_num,
  output logic [DIVW-1:0]   o_den,
  output pld_pkg::side_t    o_side
);
  import pld_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * (PW + 1);
  localparam int NW = SW + 2;

  // stage 1
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic [1:0]           cmd1;
  logic                 vld1;
  // stage 2
  logic signed [PW-1:0] p_uu [0:2];
  logic signed [PW-1:0] p_vu [0:2];
  logic signed [PW-1:0] p_cr [0:5];
  logic                 degen2;
  logic [1:0]           cmd2;
  logic                 vld2;
  // stage 3
  logic signed [PW+1:0] len2, dot;
  logic signed [PW:0]   cx, cy, cz;
  logic                 degen3;
  logic [1:0]           cmd3;
  logic                 vld3;
  // stage 4
  logic [SW-1:0]        sx, sy, sz;
  logic [DIVW-1:0]      den4;
  logic [1:0]           stat4;
  logic                 root4;
  logic                 vld4;

  logic [PW:0]          mx, my, mz;
  logic [NW-1:0]        nsum;

  function automatic logic signed [DW-1:0] sub_c(input logic [15:0] b, input logic [15:0] a);
    logic signed [CW-1:0] bs, as;
    bs = b[CW-1:0];
    as = a[CW-1:0];
    return DW'(bs) - DW'(as);
  endfunction

  always_comb begin
    mx = cx[PW] ? (PW+1)'(-cx) : (PW+1)'(cx);
    my = cy[PW] ? (PW+1)'(-cy) : (PW+1)'(cy);
    mz = cz[PW] ? (PW+1)'(-cz) : (PW+1)'(cz);
    nsum = NW'(sx) + NW'(sy) + NW'(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      o_vld <= 1'b0;
    end else if (adv) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      o_vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux   <= sub_c(in_item.end_x, in_item.start_x);
      uy   <= sub_c(in_item.end_y, in_item.start_y);
      uz   <= sub_c(in_item.end_z, in_item.start_z);
      vx   <= sub_c(in_item.point_x, in_item.start_x);
      vy   <= sub_c(in_item.point_y, in_item.start_y);
      vz   <= sub_c(in_item.point_z, in_item.start_z);
      cmd1 <= in_item.cmd;

      p_uu[0] <= ux * ux;
      p_uu[1] <= uy * uy;
      p_uu[2] <= uz * uz;
      p_vu[0] <= vx * ux;
      p_vu[1] <= vy * uy;
      p_vu[2] <= vz * uz;
      p_cr[0] <= vy * uz;
      p_cr[1] <= vz * uy;
      p_cr[2] <= vz * ux;
      p_cr[3] <= vx * uz;
      p_cr[4] <= vx * uy;
      p_cr[5] <= vy * ux;
      degen2  <= (ux == '0) && (uy == '0) && (uz == '0);
      cmd2    <= cmd1;

      len2   <= (PW+2)'(p_uu[0]) + (PW+2)'(p_uu[1]) + (PW+2)'(p_uu[2]);
      dot    <= (PW+2)'(p_vu[0]) + (PW+2)'(p_vu[1]) + (PW+2)'(p_vu[2]);
      cx     <= (PW+1)'(p_cr[0]) - (PW+1)'(p_cr[1]);
      cy     <= (PW+1)'(p_cr[2]) - (PW+1)'(p_cr[3]);
      cz     <= (PW+1)'(p_cr[4]) - (PW+1)'(p_cr[5]);
      degen3 <= degen2;
      cmd3   <= cmd2;

      // square the cross terms and decide status
      sx    <= SW'(mx) * SW'(mx);
      sy    <= SW'(my) * SW'(my);
      sz    <= SW'(mz) * SW'(mz);
      den4  <= degen3 ? DIVW'(1) : DIVW'(len2);
      root4 <= cmd3[CMD_ROOT_BIT];
      if (degen3) begin
        stat4 <= STAT_DEGEN;
      end else if (cmd3[CMD_SEG_BIT] && (dot < 0 || dot > len2)) begin
        stat4 <= STAT_OFFSEG;
      end else begin
        stat4 <= STAT_OK;
      end

      o_num         <= root4 ? (EW'(nsum) << (2 * (FB / 2))) : (EW'(nsum) << FB);
      o_den         <= den4;
      o_side.status <= stat4;
      o_side.root   <= root4;
    end
  end
endmodule
`default_nettype wire

/* rtl/pld_div.sv */
// Restoring divider, one quotient bit per pipeline stage.
// Depends on pld_pkg.
`default_nettype none
module pld_div #(
  parameter int DIVW = 36,
  parameter int EW   = 88
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   adv,
  input  wire                   i_vld,
  input  wire [EW-1:0]          i_num,
  input  wire [DIVW-1:0]        i_den,
  input  pld_pkg::side_t        i_side,
  output logic                  o_vld,
  output logic [pld_pkg::QW-1:0] o_quo,
  output pld_pkg::side_t        o_side
);
  import pld_pkg::*;

  logic            vld_s  [0:QW];
  logic [DIVW-1:0] rem_s  [0:QW];
  logic [DIVW-1:0] den_s  [0:QW];
  logic [QW-1:0]   num_s  [0:QW];
  logic [QW-1:0]   quo_s  [0:QW];
  side_t           side_s [0:QW];

  // the quotient fits in QW bits, so the bits above start out as a partial remainder
  assign vld_s[0]  = i_vld;
  assign rem_s[0]  = DIVW'(i_num >> QW);
  assign den_s[0]  = i_den;
  assign num_s[0]  = i_num[QW-1:0];
  assign quo_s[0]  = '0;
  assign side_s[0] = i_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DIVW:0] sh;
    logic          ge;
    assign sh = {rem_s[i], num_s[i][QW-1-i]};
    assign ge = sh >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (adv) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[i+1]  <= ge ? DIVW'(sh - {1'b0, den_s[i]}) : DIVW'(sh);
        den_s[i+1]  <= den_s[i];
        num_s[i+1]  <= num_s[i];
        quo_s[i+1]  <= {quo_s[i][QW-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign o_vld  = vld_s[QW];
  assign o_quo  = quo_s[QW];
  assign o_side = side_s[QW];
endmodule
`default_nettype wire

/* rtl/pld_sqrt.sv */
// Digit-by-digit integer square root, one root bit per pipeline stage.
// Depends on pld_pkg; carries the plain quotient alongside.
`default_nettype none
module pld_sqrt (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    adv,
  input  wire                    i_vld,
  input  wire [pld_pkg::QW-1:0]  i_x,
  input  pld_pkg::side_t         i_side,
  output logic                   o_vld,
  output logic [pld_pkg::QW-1:0] o_x,
  output logic [pld_pkg::RW-1:0] o_root,
  output pld_pkg::side_t         o_side
);
  import pld_pkg::*;

  logic          vld_s  [0:RW];
  logic [RW+1:0] rem_s  [0:RW];
  logic [RW-1:0] root_s [0:RW];
  logic [QW-1:0] x_s    [0:RW];
  side_t         side_s [0:RW];

  assign vld_s[0]  = i_vld;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = i_x;
  assign side_s[0] = i_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [RW+3:0] sh;
    logic [RW+3:0] trial;
    logic          ge;
    assign sh    = {rem_s[k], x_s[k][2*B+1:2*B]};
    assign trial = (RW+4)'({root_s[k], 2'b01});
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1]  <= ge ? (RW+2)'(sh - trial) : (RW+2)'(sh);
        root_s[k+1] <= {root_s[k][RW-2:0], ge};
        x_s[k+1]    <= x_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign o_vld  = vld_s[RW];
  assign o_x    = x_s[RW];
  assign o_root = root_s[RW];
  assign o_side = side_s[RW];
endmodule
`default_nettype wire

/* rtl/point_line_distance_top.sv */
// Top level of the point-to-line distance block.
// Depends on pld_pkg, pld_front, pld_div and pld_sqrt.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries one query item:
//   cmd, point P, start A and end B. Output channel out_valid / out_stall /
//   out_item returns one item per query: value and status.
//   Squared modes give floor(d^2 * 2^FRACTION_BITS), distance modes give
//   floor(d * 2^(FRACTION_BITS/2)). Coincident endpoints give the degenerate
//   status; segment modes report a projection off the segment. value is zero
//   unless status is ok.
// Throughput: one item per cycle, sustained, as long as out_stall is low.
// Stages: 5 front stages (differences, products, sums,
//   squares and status, numerator) + 50 divider stages, one quotient bit
//   each + 25 root stages, one root bit each + 1 output register.
// Stall: while an output item waits under out_stall the whole pipeline
//   holds, in_stall is raised, and nothing is lost or repeated.
// Reset: rst (synchronous) clears every valid bit; the pipeline is empty.
`default_nettype none
module point_line_distance_top #(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_stall,
  input  pld_pkg::in_t  in_item,
  output logic          out_valid,
  input  wire           out_stall,
  output pld_pkg::out_t out_item
);
  import pld_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int DIVW = PW + 2;
  localparam int NW   = 2 * (PW + 1) + 2;
  localparam int NUMW = NW + FRACTION_BITS;
  localparam int EW   = (NUMW > QW) ? NUMW : QW + 1;

  logic            adv;
  logic            f_vld, d_vld, s_vld;
  logic [EW-1:0]   f_num;
  logic [DIVW-1:0] f_den;
  side_t           f_side, d_side, s_side;
  logic [QW-1:0]   d_quo, s_quo;
  logic [RW-1:0]   s_root;

  // advance every stage unless the output item is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  pld_front #(
    .CW(COORD_WIDTH), .FB(FRACTION_BITS), .DIVW(DIVW), .EW(EW)
  ) u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(in_valid), .in_item(in_item),
    .o_vld(f_vld), .o_num(f_num), .o_den(f_den), .o_side(f_side)
  );

  pld_div #(.DIVW(DIVW), .EW(EW)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .i_vld(f_vld), .i_num(f_num), .i_den(f_den), .i_side(f_side),
    .o_vld(d_vld), .o_quo(d_quo), .o_side(d_side)
  );

  pld_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .i_vld(d_vld), .i_x(d_quo), .i_side(d_side),
    .o_vld(s_vld), .o_x(s_quo), .o_root(s_root), .o_side(s_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s_vld;
    end
  end

  // drop the value for any status but ok
  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.status <= s_side.status;
      if (s_side.status != STAT_OK) begin
        out_item.value <= '0;
      end else if (s_side.root) begin
        out_item.value <= QW'(s_root);
      end else begin
        out_item.value <= s_quo;
      end
    end
  end
endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench for point_line_distance_top: random and directed 3D point/line queries.
// Depends on pld_pkg and the block's RTL; a scoreboard class predicts and checks items.
`timescale 1ns / 100ps
`default_nettype none

class distance_scoreboard;
  pld_pkg::out_t pending[$];
  int mismatches;
  int checked;

  // floored integer square root, bit by bit
  static function logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // work out the distance result for one query
  static function pld_pkg::out_t distance_of(pld_pkg::in_t q);
    pld_pkg::out_t r;
    longint ux, uy, uz, vx, vy, vz, len2, dot, cx, cy, cz;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0] root;
    ux = longint'(q.end_x) - longint'(q.start_x);
    uy = longint'(q.end_y) - longint'(q.start_y);
    uz = longint'(q.end_z) - longint'(q.start_z);
    vx = longint'(q.point_x) - longint'(q.start_x);
    vy = longint'(q.point_y) - longint'(q.start_y);
    vz = longint'(q.point_z) - longint'(q.start_z);
    r.value = '0;
    r.status = pld_pkg::STAT_OK;
    if (ux == 0 && uy == 0 && uz == 0) begin
      r.status = pld_pkg::STAT_DEGEN;
      return r;
    end
    len2 = ux * ux + uy * uy + uz * uz;
    dot = vx * ux + vy * uy + vz * uz;
    if (q.cmd[pld_pkg::CMD_SEG_BIT] && (dot < 0 || dot > len2)) begin
      r.status = pld_pkg::STAT_OFFSEG;
      return r;
    end
    cx = vy * uz - vz * uy;
    cy = vz * ux - vx * uz;
    cz = vx * uy - vy * ux;
    // squares of the cross terms need more than 64 bits
    num = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
    quo = (num << 16) / 128'(len2);
    root = int_root(quo[63:0]);
    if (q.cmd[pld_pkg::CMD_ROOT_BIT]) r.value = root[49:0];
    else r.value = quo[49:0];
    return r;
  endfunction

  function void note_query(pld_pkg::in_t q);
    pending.push_back(distance_of(q));
  endfunction

  function void check_result(pld_pkg::out_t got);
    pld_pkg::out_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected item: value %0d status %0d",
                                     got.value, got.status);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.value !== want.value || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                 want.value, want.status, got.value, got.status);
    end
  endfunction
endclass

module testbench;
  import pld_pkg::*;

  localparam int LATENCY = 81;
  localparam int RANDOM_ITEMS = 500;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;

  distance_scoreboard board;
  longint cycles;
  int sent;
  int stall_mode;

  point_line_distance_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Bound the run; a hang is a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check every accepted result, then pick the next stall on a pattern of its
  // own: long open stretches, short bursts of stall, and a choppy mode.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_item);
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 2);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one item and hold it until accepted.
  task automatic send_query(in_t q);
    in_valid <= 1'b1;
    in_item <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_query(q);
    sent++;
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic in_t make_query(logic [1:0] c, logic signed [15:0] px,
                                     logic signed [15:0] py, logic signed [15:0] pz,
                                     logic signed [15:0] ax, logic signed [15:0] ay,
                                     logic signed [15:0] az, logic signed [15:0] bx,
                                     logic signed [15:0] by, logic signed [15:0] bz);
    in_t q;
    q = '{c, px, py, pz, ax, ay, az, bx, by, bz};
    return q;
  endfunction

  function automatic in_t random_query();
    in_t q;
    q.cmd = 2'($urandom_range(0, 3));
    q.point_x = rand_coord(); q.point_y = rand_coord(); q.point_z = rand_coord();
    q.start_x = rand_coord(); q.start_y = rand_coord(); q.start_z = rand_coord();
    q.end_x = rand_coord(); q.end_y = rand_coord(); q.end_z = rand_coord();
    // Make some lines degenerate and some points sit near or on the segment.
    case ($urandom_range(0, 9))
      0: begin
        q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
      end
      1: begin
        q.point_x = q.start_x; q.point_y = q.start_y; q.point_z = q.start_z;
      end
      2: begin
        q.point_x = q.end_x; q.point_y = q.end_y; q.point_z = q.end_z;
      end
      3: begin
        q.point_x = (q.start_x >>> 1) + (q.end_x >>> 1);
        q.point_y = (q.start_y >>> 1) + (q.end_y >>> 1);
        q.point_z = (q.start_z >>> 1) + (q.end_z >>> 1);
      end
      default: ;
    endcase
    return q;
  endfunction

  initial begin
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    int burst;
    board = new();
    cycles = 0;
    sent = 0;
    stall_mode = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    lo = 16'sh8000;
    hi = 16'sh7fff;
    // Directed: each mode on a plain case, coincident endpoints, off-segment
    // on both sides, endpoint projections, and extreme coordinates.
    for (int c = 0; c < 4; c++) begin
      send_query(make_query(2'(c), 3, 4, 0, 0, 0, 0, 10, 0, 0));
      send_query(make_query(2'(c), 5, 5, 5, 1, 2, 3, 1, 2, 3));
      send_query(make_query(2'(c), -5, 2, 0, 0, 0, 0, 10, 0, 0));
      send_query(make_query(2'(c), 15, 2, 0, 0, 0, 0, 10, 0, 0));
      send_query(make_query(2'(c), hi, lo, hi, lo, hi, lo, hi, lo, hi));
    end
    send_query(make_query(2'd2, 0, 7, 0, 0, 0, 0, 10, 0, 0));
    send_query(make_query(2'd3, 10, 7, 0, 0, 0, 0, 10, 0, 0));
    send_query(make_query(2'd1, hi, hi, hi, lo, lo, lo, lo, lo, hi));
    send_query(make_query(2'd0, lo, lo, lo, hi, hi, hi, lo, hi, hi));

    // Random: bursts of items with random gaps between them.
    while (sent < RANDOM_ITEMS + 24) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) send_query(random_query());
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Covered %0d queries in all four modes, incl. degenerate and off-segment cases;",
             sent);
    $display("%0d results checked with random gaps and output stalls.", board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire
